### rtl/core/kdlp_pkg.sv
// Shared types and constants for the key debounce and long-press qualifier.
package kdlp_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned REG_INDEX_W = 2;

    localparam logic [PERIOD_W-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [PERIOD_W-1:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic PRESS_LEVEL_RESET = 1'b0;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TAKE = 1'b1;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_PRESS_LEVEL = 2'd0,
        REG_DEBOUNCE    = 2'd1,
        REG_LONG_PRESS  = 2'd2
    } reg_index_t;

    typedef enum logic [3:0] {
        PHASE_IDLE      = 4'b0001,
        PHASE_DEB_PRESS = 4'b0010,
        PHASE_PRESSED   = 4'b0100,
        PHASE_DEB_REL   = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_LONG    = 2'd2,
        EV_RELEASE = 2'd3
    } event_t;

    typedef struct packed {
        logic                press_level;
        logic [PERIOD_W-1:0] debounce_time;
        logic [PERIOD_W-1:0] long_press_time;
    } cfg_t;

    typedef struct packed {
        phase_t              phase;
        logic [TIME_W-1:0]   entry_time;
        event_t              mail_event;
        logic                slot_free;
    } key_state_t;

endpackage

### rtl/core/kdlp_channels.sv
// Channel interfaces for sample/take items, results and register writes.
interface kdlp_sample_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic        pin_level;
    logic [31:0] time_now;

    modport source (output valid, output command, output pin_level, output time_now,
                    input ready);
    modport sink (input valid, input command, input pin_level, input time_now,
                  output ready);
endinterface

interface kdlp_result_if;
    logic       valid;
    logic       ready;
    logic       key_down;
    logic [1:0] event_code;

    modport source (output valid, output key_down, output event_code, input ready);
    modport sink (input valid, input key_down, input event_code, output ready);
endinterface

interface kdlp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/key_debounce_long_press_fsm_core.sv
// Key debounce qualifier with long-press repeat and a one-slot event mailbox.
// A result is registered: the item waits in the input register and the state
// update loads the result register.
// Throughput: one item per cycle while the result side does not stall.
// Reset clears the key state to idle with an empty mailbox and loads the
// register defaults: active level 0, debounce 20 ms, long press 1000 ms.
module key_debounce_long_press_fsm_core (
    input logic              clk,
    input logic              rst_n,
    kdlp_cfg_if.sink         cfg,
    kdlp_sample_if.sink      sample,
    kdlp_result_if.source    result
);

    kdlp_pkg::cfg_t       cfg_reg;
    kdlp_pkg::cfg_t       cfg_next;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic                 in_command_reg;
    logic                 in_pin_reg;
    logic [31:0]          in_time_reg;

    kdlp_pkg::key_state_t state_reg;
    kdlp_pkg::key_state_t state_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_key_down_reg;
    kdlp_pkg::event_t     out_event_reg;

    logic                 step_key_down;
    kdlp_pkg::event_t     step_event;
    logic                 advance;
    logic                 sample_take;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (kdlp_pkg::reg_index_t'(cfg.index))
                kdlp_pkg::REG_PRESS_LEVEL:  cfg_next.press_level = cfg.data[0];
                kdlp_pkg::REG_DEBOUNCE:     cfg_next.debounce_time = cfg.data;
                kdlp_pkg::REG_LONG_PRESS:   cfg_next.long_press_time = cfg.data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // The pipeline moves whenever the result register is empty or being drained.
    assign advance = !out_valid_reg || result.ready;
    assign sample.ready = !in_valid_reg || advance;
    assign sample_take = sample.valid && sample.ready;

    assign in_valid_next = sample.ready ? sample.valid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    kdlp_step u_step (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .command    (in_command_reg),
        .pin_level  (in_pin_reg),
        .time_now   (in_time_reg),
        .state_nxt  (state_next),
        .key_down   (step_key_down),
        .event_code (step_event)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_level <= kdlp_pkg::PRESS_LEVEL_RESET;
            cfg_reg.debounce_time <= kdlp_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_time <= kdlp_pkg::LONG_PRESS_RESET;
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.phase <= kdlp_pkg::PHASE_IDLE;
            state_reg.entry_time <= '0;
            state_reg.mail_event <= kdlp_pkg::EV_NONE;
            state_reg.slot_free <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance && in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            in_command_reg <= sample.command;
            in_pin_reg <= sample.pin_level;
            in_time_reg <= sample.time_now;
        end
        if (advance && in_valid_reg)
        begin
            out_key_down_reg <= step_key_down;
            out_event_reg <= step_event;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.key_down = out_key_down_reg;
    assign result.event_code = out_event_reg;

endmodule

### rtl/core/kdlp_step.sv
// Next-state logic of the key qualifier and its one-slot event mailbox.
module kdlp_step (
    input  kdlp_pkg::cfg_t       cfg,
    input  kdlp_pkg::key_state_t state_cur,
    input  logic                 command,
    input  logic                 pin_level,
    input  logic [31:0]          time_now,
    output kdlp_pkg::key_state_t state_nxt,
    output logic                 key_down,
    output kdlp_pkg::event_t     event_code
);

    logic                held;
    logic [31:0]         elapsed;
    logic [15:0]         limit;
    logic                expired;
    logic                raise;
    kdlp_pkg::event_t    raised_event;

    assign held = (pin_level == cfg.press_level);
    assign elapsed = time_now - state_cur.entry_time;
    // Only the pressed phase times against the long-press period.
    assign limit = (state_cur.phase == kdlp_pkg::PHASE_PRESSED) ?
                   cfg.long_press_time : cfg.debounce_time;
    assign expired = (elapsed >= {16'd0, limit});

    always_comb
    begin
        state_nxt = state_cur;
        event_code = kdlp_pkg::EV_NONE;
        raise = 1'b0;
        raised_event = kdlp_pkg::EV_NONE;
        if (command == kdlp_pkg::CMD_TAKE)
        begin
            event_code = state_cur.mail_event;
            state_nxt.mail_event = kdlp_pkg::EV_NONE;
            state_nxt.slot_free = 1'b1;
        end
        else
        begin
            case (state_cur.phase)
                kdlp_pkg::PHASE_IDLE:
                begin
                    if (held)
                    begin
                        state_nxt.phase = kdlp_pkg::PHASE_DEB_PRESS;
                        state_nxt.entry_time = time_now;
                    end
                end
                kdlp_pkg::PHASE_DEB_PRESS:
                begin
                    if (!held)
                    begin
                        state_nxt.phase = kdlp_pkg::PHASE_IDLE;
                    end
                    else if (expired)
                    begin
                        state_nxt.phase = kdlp_pkg::PHASE_PRESSED;
                        state_nxt.entry_time = time_now;
                        raise = 1'b1;
                        raised_event = kdlp_pkg::EV_PRESS;
                    end
                end
                kdlp_pkg::PHASE_PRESSED:
                begin
                    if (!held)
                    begin
                        state_nxt.phase = kdlp_pkg::PHASE_DEB_REL;
                        state_nxt.entry_time = time_now;
                    end
                    else if (expired)
                    begin
                        state_nxt.entry_time = time_now;
                        raise = 1'b1;
                        raised_event = kdlp_pkg::EV_LONG;
                    end
                end
                kdlp_pkg::PHASE_DEB_REL:
                begin
                    // A bounce back to held keeps the entry time set when the release debounce began.
                    if (held)
                    begin
                        state_nxt.phase = kdlp_pkg::PHASE_PRESSED;
                    end
                    else if (expired)
                    begin
                        state_nxt.phase = kdlp_pkg::PHASE_IDLE;
                        raise = 1'b1;
                        raised_event = kdlp_pkg::EV_RELEASE;
                    end
                end
                default:
                begin
                    state_nxt.phase = kdlp_pkg::PHASE_IDLE;
                end
            endcase
            // An event raised while the mailbox is occupied is dropped.
            if (raise && state_cur.slot_free)
            begin
                state_nxt.mail_event = raised_event;
                state_nxt.slot_free = 1'b0;
            end
        end
    end

    assign key_down = (state_nxt.phase == kdlp_pkg::PHASE_PRESSED) ||
                      (state_nxt.phase == kdlp_pkg::PHASE_DEB_PRESS);

endmodule

### rtl/core/kdlp_checker.sv
// Port-level checks for the key qualifier, bound to the top level.
module kdlp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       sample_valid,
    input logic       sample_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic       result_key_down,
    input logic [1:0] result_event_code
);

    logic       in_txn;
    logic       out_txn;
    logic [1:0] outstanding_reg;
    logic [1:0] outstanding_next;

    assign in_txn = sample_valid && sample_ready;
    assign out_txn = result_valid && result_ready;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (in_txn && !out_txn)
        begin
            outstanding_next = outstanding_reg + 2'd1;
        end
        else if (!in_txn && out_txn)
        begin
            outstanding_next = outstanding_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= 2'd0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // Every result transaction answers an earlier input transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_txn |-> (outstanding_reg != 2'd0))
        else $error("result transaction without a pending input item");

    // At most two items are ever held inside the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg != 2'd3)
        else $error("more than two items in flight");

    // With the result side empty, the block must be able to take an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> sample_ready)
        else $error("input stalled while the result register is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(result_key_down) && $stable(result_event_code)))
        else $error("stalled result changed or was dropped");

endmodule

bind key_debounce_long_press_fsm_core kdlp_checker u_kdlp_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .sample_valid      (sample.valid),
    .sample_ready      (sample.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_key_down   (result.key_down),
    .result_event_code (result.event_code)
);

### tb/key_debounce_long_press_fsm_core_tb.sv
// Self-checking testbench for the key debounce and long-press qualifier core.
module key_debounce_long_press_fsm_core_tb;

    typedef struct packed {
        logic                        command;
        logic                        pin_level;
        logic [kdlp_pkg::TIME_W-1:0] time_now;
    } key_sample_t;

    typedef struct packed {
        logic             key_down;
        kdlp_pkg::event_t event_code;
    } key_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    kdlp_cfg_if    cfg_ch();
    kdlp_sample_if smp_ch();
    kdlp_result_if res_ch();

    key_debounce_long_press_fsm_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .sample (smp_ch),
        .result (res_ch)
    );

    // Shadow of the key qualifier: registers and state.
    kdlp_pkg::cfg_t              cfg_shadow = '{kdlp_pkg::PRESS_LEVEL_RESET,
                                                kdlp_pkg::DEBOUNCE_RESET,
                                                kdlp_pkg::LONG_PRESS_RESET};
    kdlp_pkg::phase_t            key_phase = kdlp_pkg::PHASE_IDLE;
    logic [kdlp_pkg::TIME_W-1:0] entry_ts = '0;
    kdlp_pkg::event_t            mailbox = kdlp_pkg::EV_NONE;
    logic                        mailbox_free = 1'b1;

    key_sample_t                 sample_backlog[$];
    key_report_t                 pending_reports[$];
    key_report_t                 want;

    int unsigned                 mismatch_count = 0;
    int unsigned                 phase_items = 0;
    logic [kdlp_pkg::TIME_W-1:0] clock_ms = '0;
    logic                        steady = 1'b0;
    logic                        hold_armed = 1'b0;
    logic                        hold_spent = 1'b0;
    int unsigned                 hold_left = 0;

    always #5 clk = ~clk;

    task automatic note_mismatch(string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    function automatic void post_key_event(kdlp_pkg::event_t ev);
        if (mailbox_free)
        begin
            mailbox = ev;
            mailbox_free = 1'b0;
        end
    endfunction

    function automatic key_report_t qualify_key(key_sample_t it);
        key_report_t                 r;
        logic                        held;
        logic [kdlp_pkg::TIME_W-1:0] elapsed;
        r.event_code = kdlp_pkg::EV_NONE;
        if (it.command == kdlp_pkg::CMD_SAMPLE)
        begin
            held = (it.pin_level == cfg_shadow.press_level);
            elapsed = it.time_now - entry_ts;
            case (key_phase)
                kdlp_pkg::PHASE_IDLE:
                    if (held)
                    begin
                        key_phase = kdlp_pkg::PHASE_DEB_PRESS;
                        entry_ts = it.time_now;
                    end
                kdlp_pkg::PHASE_DEB_PRESS:
                    if (!held)
                        key_phase = kdlp_pkg::PHASE_IDLE;
                    else if (elapsed >= kdlp_pkg::TIME_W'(cfg_shadow.debounce_time))
                    begin
                        key_phase = kdlp_pkg::PHASE_PRESSED;
                        entry_ts = it.time_now;
                        post_key_event(kdlp_pkg::EV_PRESS);
                    end
                kdlp_pkg::PHASE_PRESSED:
                    if (!held)
                    begin
                        key_phase = kdlp_pkg::PHASE_DEB_REL;
                        entry_ts = it.time_now;
                    end
                    else if (elapsed >= kdlp_pkg::TIME_W'(cfg_shadow.long_press_time))
                    begin
                        entry_ts = it.time_now;
                        post_key_event(kdlp_pkg::EV_LONG);
                    end
                default:
                    // A bounce back to the held level keeps the entry time, so
                    // long-press timing resumes from the last reference.
                    if (held)
                        key_phase = kdlp_pkg::PHASE_PRESSED;
                    else if (elapsed >= kdlp_pkg::TIME_W'(cfg_shadow.debounce_time))
                    begin
                        key_phase = kdlp_pkg::PHASE_IDLE;
                        post_key_event(kdlp_pkg::EV_RELEASE);
                    end
            endcase
        end
        else
        begin
            r.event_code = mailbox;
            mailbox = kdlp_pkg::EV_NONE;
            mailbox_free = 1'b1;
        end
        r.key_down = (key_phase == kdlp_pkg::PHASE_PRESSED) ||
                     (key_phase == kdlp_pkg::PHASE_DEB_PRESS);
        return r;
    endfunction

    // Sample channel driver; the prediction is made when a transaction is accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (smp_ch.valid && smp_ch.ready)
                pending_reports.push_back(qualify_key({smp_ch.command, smp_ch.pin_level,
                                                       smp_ch.time_now}));
            if (!smp_ch.valid || smp_ch.ready)
            begin
                if (sample_backlog.size() != 0 && (steady || $urandom_range(99) >= 36))
                begin
                    {smp_ch.command, smp_ch.pin_level, smp_ch.time_now}
                        <= sample_backlog.pop_front();
                    smp_ch.valid <= 1'b1;
                end
                else
                    smp_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure outside the steady phase.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_reports.size() == 0)
                    note_mismatch("result transaction with nothing expected");
                else
                begin
                    want = pending_reports.pop_front();
                    if (res_ch.key_down !== want.key_down)
                        note_mismatch($sformatf("key_down %b, expected %b",
                                                res_ch.key_down, want.key_down));
                    if (res_ch.event_code !== want.event_code)
                        note_mismatch($sformatf("event_code %0d, expected %0d",
                                                res_ch.event_code, want.event_code));
                end
            end
            res_ch.ready <= (hold_left == 0) && (steady || $urandom_range(99) >= 36);
        end
    end

    // Long receiver hold-off, armed once, so the pipeline fills and stalls its input.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_armed && !hold_spent)
        begin
            hold_left <= 90;
            hold_spent <= 1'b1;
        end
    end

    task automatic write_register(kdlp_pkg::reg_index_t idx,
                                  logic [kdlp_pkg::PERIOD_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            kdlp_pkg::REG_PRESS_LEVEL: cfg_shadow.press_level = value[0];
            kdlp_pkg::REG_DEBOUNCE:    cfg_shadow.debounce_time = value;
            default:                   cfg_shadow.long_press_time = value;
        endcase
    endtask

    task automatic apply_settings(logic level, logic [kdlp_pkg::PERIOD_W-1:0] deb,
                                  logic [kdlp_pkg::PERIOD_W-1:0] lp);
        // Upper data bits are junk for the one-bit register.
        write_register(kdlp_pkg::REG_PRESS_LEVEL, {15'($urandom), level});
        write_register(kdlp_pkg::REG_DEBOUNCE, deb);
        write_register(kdlp_pkg::REG_LONG_PRESS, lp);
    endtask

    task automatic wait_drained();
        while (sample_backlog.size() != 0 || smp_ch.valid || pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_item(logic cmd, logic pin, logic [kdlp_pkg::TIME_W-1:0] ts);
        sample_backlog.push_back({cmd, pin, ts});
        phase_items++;
    endtask

    task automatic push_take();
        // Pin and time are don't-care on a take, so they get random values.
        push_item(kdlp_pkg::CMD_TAKE, 1'($urandom), $urandom);
    endtask

    task automatic queue_key(logic pin, int unsigned max_step);
        clock_ms += $urandom_range(max_step);
        push_item(kdlp_pkg::CMD_SAMPLE, pin, clock_ms);
        if ($urandom_range(3) == 0)
            push_take();
    endtask

    // One press, hold and release with random bounces and sample spacing.
    task automatic queue_gesture();
        logic        act;
        int unsigned deb;
        int unsigned lp;
        act = cfg_shadow.press_level;
        deb = cfg_shadow.debounce_time;
        lp = cfg_shadow.long_press_time;
        repeat ($urandom_range(2))
        begin
            queue_key(act, deb / 2 + 1);
            queue_key(!act, deb / 2 + 1);
        end
        repeat ($urandom_range(20, 3)) queue_key(act, lp / 3 + deb / 2 + 2);
        repeat ($urandom_range(2))
        begin
            queue_key(!act, deb / 2 + 1);
            queue_key(act, deb / 2 + 1);
        end
        repeat ($urandom_range(4, 1)) queue_key(!act, deb + 5);
    endtask

    task automatic queue_directed();
        push_take();
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b1, 32'd5);
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b0, 32'd10);
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b1, 32'd15);
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b0, 32'd100);
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b0, 32'd120);
        // The long press here finds the press still waiting and is lost.
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b0, 32'd1120);
        push_take();
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b0, 32'd2120);
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b1, 32'd2130);
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b0, 32'd2140);
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b0, 32'd3130);
        push_take();
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b1, 32'd3200);
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b1, 32'd3220);
        push_take();
        push_take();
        // Debounce across the timestamp wrap, then the top timestamp.
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b0, 32'hFFFF_FFF0);
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b0, 32'h0000_0004);
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b1, 32'hFFFF_FFFF);
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b1, 32'h0000_0000);
        push_item(kdlp_pkg::CMD_SAMPLE, 1'b1, 32'h0000_0014);
        push_item(kdlp_pkg::CMD_TAKE, 1'b0, 32'h0000_0000);
        push_item(kdlp_pkg::CMD_TAKE, 1'b1, 32'hFFFF_FFFF);
    endtask

    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = kdlp_pkg::REG_PRESS_LEVEL;
        cfg_ch.data = '0;
        smp_ch.valid = 1'b0;
        smp_ch.command = kdlp_pkg::CMD_SAMPLE;
        smp_ch.pin_level = 1'b0;
        smp_ch.time_now = '0;
        res_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: ;
                1: apply_settings(1'b1, 16'd0, 16'd0);
                2: apply_settings(1'b0, 16'hFFFF, 16'hFFFF);
                3: apply_settings(1'b1, 16'd5, 16'd40);
                default: apply_settings(1'($urandom), 16'($urandom_range(60)),
                                        16'($urandom_range(400)));
            endcase
            @(negedge clk);
            steady <= (phase == 2);
            if (phase == 4)
                hold_armed <= 1'b1;
            phase_items = 0;
            clock_ms = (phase == 1) ? 32'hFFFF_FF80 : $urandom;
            if (phase == 0)
                queue_directed();
            while (phase_items < 130)
            begin
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(3, 1))
                        push_item(1'($urandom), 1'($urandom), $urandom);
                else
                    queue_gesture();
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("key_debounce_long_press_fsm_core: match");
        else
            $display("key_debounce_long_press_fsm_core: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("key_debounce_long_press_fsm_core: mismatch");
        $finish;
    end

endmodule

### filelist.f
rtl/core/kdlp_pkg.sv
rtl/core/kdlp_channels.sv
rtl/core/kdlp_step.sv
rtl/core/key_debounce_long_press_fsm_core.sv
rtl/core/kdlp_checker.sv
tb/key_debounce_long_press_fsm_core_tb.sv
